// ----- rtl/vrd_pkg.sv -----
`timescale 1ns / 1ps

package vrd_pkg;

  localparam int unsigned ClientsDefault = 3;
  localparam int unsigned BaseHzDefault  = 1024;

  localparam logic [31:0] LcgMul = 32'd1103515245;
  localparam logic [31:0] LcgAdd = 32'd12345;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_OPEN    = 3'd1,
    CMD_CLOSE   = 3'd2,
    CMD_POLL    = 3'd3,
    CMD_SETRATE = 3'd4,
    CMD_RANDOM  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [1:0]         client;
    logic signed [31:0] rate_hz;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        ready_res;
    logic [14:0] random_value;
  } rsp_t;

  typedef struct packed {
    logic tick;
    logic open;
    logic close;
    logic poll;
    logic setrate;
    logic random;
    logic capture;
  } ctrl_t;

endpackage

// ----- rtl/virtual_rate_divider_core.sv -----
// A request accepted at one clock edge gives its result, marked by done_o,
// in the following cycle; every command, tick included, is handled the same way.
// Throughput: one request per cycle, as all client registers update in parallel.
// busy_o never rises, and the receiver cannot stall the one-cycle result strobe.
// Reset (asynchronous, active low) sets every divisor to 1, every countdown to 0
// and the time counter to 0; no clearing pass is needed.
`timescale 1ns / 1ps

module virtual_rate_divider_core
  import vrd_pkg::*;
#(
  parameter int unsigned CLIENTS = ClientsDefault,
  parameter int unsigned BASE_HZ = BaseHzDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output rsp_t rsp_o
);

  ctrl_t ctrl;

  vrd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (req_i.cmd),
    .ctrl_o  (ctrl),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  vrd_datapath #(
    .CLIENTS (CLIENTS),
    .BASE_HZ (BASE_HZ)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- rtl/vrd_ctrl.sv -----
`timescale 1ns / 1ps

module vrd_ctrl
  import vrd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  [2:0] cmd_i,
  output ctrl_t ctrl_o,
  output logic  busy_o,
  output logic  done_o
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_RESULT = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.capture = accept;
    if (accept) begin
      unique case (cmd_i)
        CMD_TICK:    ctrl_o.tick    = 1'b1;
        CMD_OPEN:    ctrl_o.open    = 1'b1;
        CMD_CLOSE:   ctrl_o.close   = 1'b1;
        CMD_POLL:    ctrl_o.poll    = 1'b1;
        CMD_SETRATE: ctrl_o.setrate = 1'b1;
        CMD_RANDOM:  ctrl_o.random  = 1'b1;
        default:     ctrl_o.tick    = 1'b0;
      endcase
    end
  end

  always_comb begin
    unique case (state_q)
      ST_IDLE:   state_d = accept ? ST_RESULT : ST_IDLE;
      ST_RESULT: state_d = accept ? ST_RESULT : ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign done_o = (state_q == ST_RESULT);

endmodule

// ----- rtl/vrd_datapath.sv -----
`timescale 1ns / 1ps

module vrd_datapath
  import vrd_pkg::*;
#(
  parameter int unsigned CLIENTS = ClientsDefault,
  parameter int unsigned BASE_HZ = BaseHzDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctrl_t ctrl_i,
  input  req_t  req_i,
  output rsp_t  rsp_o
);

  localparam int unsigned DW = $clog2(BASE_HZ + 1);
  localparam logic [DW-1:0] HalfDiv = DW'(BASE_HZ / 2);
  localparam logic [31:0] BaseHz32 = 32'(BASE_HZ);

  logic [DW-1:0] divisor_q   [CLIENTS];
  logic [DW-1:0] divisor_d   [CLIENTS];
  logic [DW-1:0] countdown_q [CLIENTS];
  logic [DW-1:0] countdown_d [CLIENTS];
  logic [31:0]   time_q, time_d;
  logic [31:0]   lcg_next;
  rsp_t          rsp_q, rsp_d;

  logic          valid;
  logic [DW-1:0] sel_cd;
  logic          rate_ok;
  logic [4:0]    shamt;
  logic [DW-1:0] new_div;
  logic [31:0]   rate_u;

  assign valid  = ({30'd0, req_i.client} < 32'(CLIENTS));
  assign rate_u = req_i.rate_hz;

  always_comb begin
    sel_cd = '0;
    for (int i = 0; i < CLIENTS; i++) begin
      if ({30'd0, req_i.client} == 32'(i)) begin
        sel_cd = countdown_q[i];
      end
    end
  end

  always_comb begin
    shamt = '0;
    for (int b = 1; b < 32; b++) begin
      if (rate_u[b]) begin
        shamt = shamt | 5'(b);
      end
    end
  end

  assign rate_ok = (req_i.rate_hz > 32'sd1) && (req_i.rate_hz <= $signed(BaseHz32)) &&
                   ((rate_u & (rate_u - 32'd1)) == 32'd0);
  assign new_div = DW'(BaseHz32 >> shamt);

  assign lcg_next = time_q * LcgMul + LcgAdd;

  always_comb begin
    time_d = time_q;
    if (ctrl_i.tick) begin
      time_d = time_q + 32'd1;
    end else if (ctrl_i.random) begin
      time_d = lcg_next;
    end
  end

  always_comb begin
    for (int i = 0; i < CLIENTS; i++) begin
      divisor_d[i]   = divisor_q[i];
      countdown_d[i] = countdown_q[i];
      if (ctrl_i.tick && (countdown_q[i] != '0)) begin
        countdown_d[i] = countdown_q[i] - DW'(1);
      end
      if ({30'd0, req_i.client} == 32'(i)) begin
        if (ctrl_i.open) begin
          divisor_d[i]   = HalfDiv;
          countdown_d[i] = HalfDiv;
        end
        if (ctrl_i.close) begin
          divisor_d[i]   = DW'(1);
          countdown_d[i] = '0;
        end
        if (ctrl_i.poll && (countdown_q[i] == '0)) begin
          countdown_d[i] = divisor_q[i];
        end
        if (ctrl_i.setrate && rate_ok) begin
          divisor_d[i] = new_div;
        end
      end
    end
  end

  always_comb begin
    rsp_d              = '0;
    rsp_d.status       = ctrl_i.setrate && valid && !rate_ok;
    rsp_d.ready_res    = ctrl_i.poll && valid && (sel_cd == '0);
    rsp_d.random_value = ctrl_i.random ? lcg_next[30:16] : 15'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      for (int i = 0; i < CLIENTS; i++) begin
        divisor_q[i]   <= DW'(1);
        countdown_q[i] <= '0;
      end
    end else begin
      time_q <= time_d;
      for (int i = 0; i < CLIENTS; i++) begin
        divisor_q[i]   <= divisor_d[i];
        countdown_q[i] <= countdown_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ----- tb/sv/tb_virtual_rate_divider_core.sv -----
`timescale 1ns / 1ps

module tb_virtual_rate_divider_core;
  import vrd_pkg::*;

  localparam int          NumClients = int'(ClientsDefault);
  localparam int          BaseHz     = int'(BaseHzDefault);
  localparam logic [2:0]  CmdSpare6  = 3'd6;
  localparam logic [2:0]  CmdSpare7  = 3'd7;
  localparam logic [1:0]  ClientNone = 2'd3;
  localparam int          ItemsPerPhase = 100;

  // Mirrors the per-client divisors, countdowns and the time counter, and
  // keeps the responses still owed by the block in transfer order.
  class rate_divider_scoreboard;
    logic [10:0] divisor [NumClients];
    logic [10:0] countdown [NumClients];
    logic [31:0] tick_time;
    rsp_t        owed_rsp [$];
    int          mismatches;

    function new();
      for (int i = 0; i < NumClients; i++) begin
        divisor[i]   = 11'd1;
        countdown[i] = 11'd0;
      end
      tick_time  = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return owed_rsp.size();
    endfunction

    function void note_request(req_t r);
      rsp_t        rsp;
      int          slot;
      int          freq;
      bit          known;
      rsp   = '0;
      slot  = int'(r.client);
      known = slot < NumClients;
      freq  = int'(r.rate_hz);
      case (r.cmd)
        CMD_TICK: begin
          for (int i = 0; i < NumClients; i++) begin
            if (countdown[i] != 0) countdown[i] = countdown[i] - 11'd1;
          end
          tick_time = tick_time + 32'd1;
        end
        CMD_OPEN: begin
          if (known) begin
            divisor[slot]   = 11'(BaseHz / 2);
            countdown[slot] = 11'(BaseHz / 2);
          end
        end
        CMD_CLOSE: begin
          if (known) begin
            divisor[slot]   = 11'd1;
            countdown[slot] = 11'd0;
          end
        end
        CMD_POLL: begin
          if (known && countdown[slot] == 0) begin
            countdown[slot] = divisor[slot];
            rsp.ready_res   = 1'b1;
          end
        end
        CMD_SETRATE: begin
          if (known) begin
            if (freq < 2 || freq > BaseHz || (freq & (freq - 1)) != 0) begin
              rsp.status = 1'b1;
            end else begin
              divisor[slot] = 11'(BaseHz / freq);
            end
          end
        end
        CMD_RANDOM: begin
          tick_time        = tick_time * LcgMul + LcgAdd;
          rsp.random_value = tick_time[30:16];
        end
        default: begin
        end
      endcase
      owed_rsp.push_back(rsp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (owed_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: response with none outstanding: status=%0b ready=%0b random=%0h",
                   $realtime, got.status, got.ready_res, got.random_value);
        end
        return;
      end
      want = owed_rsp.pop_front();
      if (got.status !== want.status || got.ready_res !== want.ready_res ||
          got.random_value !== want.random_value) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected status=%0b ready=%0b random=%0h, got status=%0b ready=%0b random=%0h",
                   $realtime, want.status, want.ready_res, want.random_value,
                   got.status, got.ready_res, got.random_value);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  rate_divider_scoreboard sb;
  int idle_pct;

  virtual_rate_divider_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_response(rsp_o);
      if (start && !busy) sb.note_request(req_i);
    end
  end

  function automatic req_t make_req(logic [2:0] cmd, logic [1:0] client, logic [31:0] rate);
    req_t r;
    r.cmd     = cmd;
    r.client  = client;
    r.rate_hz = rate;
    return r;
  endfunction

  // Ticks dominate so that countdowns actually run out and polls come back ready.
  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    pick      = $urandom_range(99);
    r.client  = ($urandom_range(9) == 0) ? ClientNone : 2'($urandom_range(NumClients - 1));
    r.rate_hz = $urandom();
    if (pick < 40) begin
      r.cmd = CMD_TICK;
    end else if (pick < 47) begin
      r.cmd = CMD_OPEN;
    end else if (pick < 55) begin
      r.cmd = CMD_CLOSE;
    end else if (pick < 75) begin
      r.cmd = CMD_POLL;
    end else if (pick < 88) begin
      r.cmd = CMD_SETRATE;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: r.rate_hz = 32'sd1 <<< $urandom_range(1, 10);
        6:                r.rate_hz = $urandom_range(0, 2 * BaseHz);
        7:                r.rate_hz = -($urandom_range(1, 4));
        default:          r.rate_hz = $urandom();
      endcase
    end else if (pick < 97) begin
      r.cmd = CMD_RANDOM;
    end else begin
      r.cmd = ($urandom_range(1) == 0) ? CmdSpare6 : CmdSpare7;
    end
    return r;
  endfunction

  task automatic send_request(req_t r);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_responses();
    start <= 1'b0;
    do @(negedge clk_i); while (sb.pending() > 0);
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_request(make_req(CMD_TICK, 2'd0, 32'h0));
    send_request(make_req(CMD_OPEN, 2'd0, 32'hFFFF_FFFF));
    send_request(make_req(CMD_POLL, 2'd0, 32'h0));
    send_request(make_req(CMD_CLOSE, 2'd0, 32'h0));
    send_request(make_req(CMD_POLL, 2'd0, 32'h0));
    send_request(make_req(CMD_TICK, 2'd2, 32'hFFFF_FFFF));
    send_request(make_req(CMD_POLL, 2'd0, 32'h0));
    send_request(make_req(CMD_SETRATE, 2'd1, 32'd2));
    send_request(make_req(CMD_SETRATE, 2'd2, 32'd1024));
    send_request(make_req(CMD_SETRATE, 2'd2, 32'd1));
    send_request(make_req(CMD_SETRATE, 2'd2, 32'd0));
    send_request(make_req(CMD_SETRATE, 2'd2, 32'hFFFF_FFFF));
    send_request(make_req(CMD_SETRATE, 2'd2, 32'd2048));
    send_request(make_req(CMD_SETRATE, 2'd2, 32'd3));
    send_request(make_req(CMD_SETRATE, 2'd2, 32'h8000_0000));
    send_request(make_req(CMD_SETRATE, 2'd2, 32'h7FFF_FFFF));
    send_request(make_req(CMD_OPEN, ClientNone, 32'h0));
    send_request(make_req(CMD_CLOSE, ClientNone, 32'h0));
    send_request(make_req(CMD_POLL, ClientNone, 32'h0));
    send_request(make_req(CMD_SETRATE, ClientNone, 32'd3));
    send_request(make_req(CMD_RANDOM, ClientNone, 32'hFFFF_FFFF));
    send_request(make_req(CMD_RANDOM, 2'd0, 32'h0));
    send_request(make_req(CmdSpare6, 2'd1, 32'd4));
    send_request(make_req(CmdSpare7, 2'd2, 32'd8));
    send_request(make_req(CMD_POLL, 2'd2, 32'h0));
  endtask

  initial begin
    int phase_idle [4];
    phase_idle = '{0, 75, 0, 22};
    sb       = new();
    idle_pct = 0;
    rst_ni   = 1'b0;
    start    = 1'b0;
    req_i    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain_responses();

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      repeat (ItemsPerPhase) send_request(random_req());
      drain_responses();
    end

    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
